### rtl/kvmt_pkg.sv
// Shared types and constants for the key-value table.
// Holds the request/response payload structs, op and status codes,
// and the controller/datapath command and status bundles.
package kvmt_pkg;

	// Table geometry
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 31;

	// Operation codes
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Read value returned on a miss and for non-get operations
	localparam logic [31:0] MISS_WORD = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        [1:0]       op;
		logic signed [KEY_W-1:0] key;
		logic        [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] read_value;
	} rsp_t;

	// One stored slot
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/key_value_map_table_top.sv
// Key-value table: each request scans all ENTRIES slots through one memory read port.
// Requests are taken one at a time: the next is accepted only after the current one commits,
// since the slot scan goes through the one read port; commit waits for a free output register.
// A finished response waits in the output register while the next request is taken.
// Reset (arst_n, async, active low) clears the valid bits at once; no clearing pass.
// Slot key/value storage is not reset. Depends on kvmt_pkg, kvmt_ctrl, kvmt_dp.
module key_value_map_table_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  kvmt_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output kvmt_pkg::rsp_t  out_data
);

	kvmt_pkg::cmd_t cmd;
	kvmt_pkg::sts_t sts;

	// Sequence the request
	kvmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Scan, update and respond
	kvmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	// One request at a time: no new accept right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// A new response appears only from a commit
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit))
		else $error("response raised without commit");

	// Failed operations return the miss word
	a_miss_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != kvmt_pkg::ST_OK) |->
		(out_data.read_value == kvmt_pkg::MISS_WORD))
		else $error("non-ok status with a read value");

	// Commit never lands on a full output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while output register busy");
`endif

endmodule

### rtl/kvmt_ctrl.sv
// Controller state machine for the key-value table.
// Sequences accept, slot scan, drain and commit; uses kvmt_pkg.
module kvmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  kvmt_pkg::sts_t  sts,
	output kvmt_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Decode commands and next state
	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### rtl/kvmt_dp.sv
// Datapath for the key-value table: slot memory, valid bits, scan
// address, match and free-slot tracking, and the output register; uses kvmt_pkg.
module kvmt_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  kvmt_pkg::req_t  in_data,
	input  kvmt_pkg::cmd_t  cmd,
	output kvmt_pkg::sts_t  sts,
	output logic            out_valid,
	input  logic            out_ready,
	output kvmt_pkg::rsp_t  out_data
);

	// Slot storage and valid bits
	kvmt_pkg::slot_t                  mem_q [kvmt_pkg::ENTRIES];
	logic [kvmt_pkg::ENTRIES-1:0]     slot_valid_q;

	// Latched request
	kvmt_pkg::req_t                   req_q;

	// Scan address and read stage
	logic [kvmt_pkg::IDX_W-1:0]       addr_q;
	logic [kvmt_pkg::IDX_W-1:0]       addr_s1;
	logic                             rd_ok_s1;
	logic                             vld_s1;
	kvmt_pkg::slot_t                  rd_s1;

	// Search results
	logic                             found_q;
	logic [kvmt_pkg::IDX_W-1:0]       hit_idx_q;
	logic [kvmt_pkg::VAL_W-1:0]       hit_val_q;
	logic                             free_found_q;
	logic [kvmt_pkg::IDX_W-1:0]       free_idx_q;

	// Output register
	logic                             out_valid_q;
	kvmt_pkg::rsp_t                   out_q;

	// Commit decode
	logic                             wr_en;
	logic                             set_valid;
	logic                             clr_valid;
	logic [kvmt_pkg::IDX_W-1:0]       wr_idx;
	kvmt_pkg::rsp_t                   rsp_nxt;
	logic                             match_s1;

	assign sts.scan_last = (addr_q == kvmt_pkg::IDX_W'(kvmt_pkg::ENTRIES - 1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	assign match_s1 = rd_ok_s1 && vld_s1 && (rd_s1.key == req_q.key);

	// Decide the table update and the response for the finished search
	always_comb begin
		wr_en              = 1'b0;
		set_valid          = 1'b0;
		clr_valid          = 1'b0;
		wr_idx             = found_q ? hit_idx_q : free_idx_q;
		rsp_nxt.status     = kvmt_pkg::ST_OK;
		rsp_nxt.read_value = kvmt_pkg::MISS_WORD;
		case (req_q.op)
			kvmt_pkg::OP_PUT: begin
				if (found_q) begin
					wr_en = 1'b1;
				end else if (free_found_q) begin
					wr_en     = 1'b1;
					set_valid = 1'b1;
				end else begin
					rsp_nxt.status = kvmt_pkg::ST_FULL;
				end
			end
			kvmt_pkg::OP_GET: begin
				if (found_q) begin
					rsp_nxt.read_value = $signed({1'b0, hit_val_q});
				end else begin
					rsp_nxt.status = kvmt_pkg::ST_NONE;
				end
			end
			kvmt_pkg::OP_REMOVE: begin
				if (found_q) begin
					clr_valid = 1'b1;
				end else begin
					rsp_nxt.status = kvmt_pkg::ST_NONE;
				end
			end
			default: begin
				// unused code: no operation
			end
		endcase
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem_q[wr_idx] <= {req_q.key, req_q.value};
		end
		if (cmd.scan) begin
			rd_s1 <= mem_q[addr_q];
		end
	end

	// Update valid bits on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.commit) begin
			if (set_valid) begin
				slot_valid_q[wr_idx] <= 1'b1;
			end
			if (clr_valid) begin
				slot_valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= in_data;
		end
	end

	// Advance scan address and read stage; track hit and lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			addr_s1      <= '0;
			rd_ok_s1     <= 1'b0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			hit_idx_q    <= '0;
			hit_val_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			rd_ok_s1 <= cmd.scan;
			if (cmd.start) begin
				addr_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					addr_q  <= addr_q + 1'b1;
					addr_s1 <= addr_q;
					vld_s1  <= slot_valid_q[addr_q];
					if (!slot_valid_q[addr_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= addr_q;
					end
				end
				if (match_s1 && !found_q) begin
					found_q   <= 1'b1;
					hit_idx_q <= addr_s1;
					hit_val_q <= rd_s1.value;
				end
			end
		end
	end

	// Hold the response until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= rsp_nxt;
		end
	end

endmodule
